### sv/sfpa_pkg.sv
// ----------------------------------------------------------------------------
// Saturating fixed-point ALU package
// Word format constants, opcode codes and helper functions shared by the
// channel interfaces and the ALU datapath.
// ----------------------------------------------------------------------------
package sfpa_pkg;

    // Fixed-point word format.
    localparam int TOTAL_BITS = 16;
    localparam int FRAC_BITS  = 8;

    // Fixed widths of the item fields.
    localparam int OPCODE_BITS = 3;
    localparam int FIELD_BITS  = 16;

    // Operand word after sign extension to at least the field width.
    localparam int EXT_BITS  = (TOTAL_BITS > FIELD_BITS) ? TOTAL_BITS : FIELD_BITS;
    // Full product of two operands.
    localparam int PROD_BITS = 2 * TOTAL_BITS;
    // Unsaturated intermediate: wide enough for the rounded product and for
    // the largest left shift of the approximate divide.
    localparam int WIDE_BITS = (2 * TOTAL_BITS + 1 > TOTAL_BITS + FRAC_BITS + 1) ?
                               2 * TOTAL_BITS + 1 : TOTAL_BITS + FRAC_BITS + 1;
    // Largest shift distance of the approximate divide, either direction.
    localparam int DIV_AMT_MAX  = (TOTAL_BITS - FRAC_BITS > FRAC_BITS + 1) ?
                                  TOTAL_BITS - FRAC_BITS : FRAC_BITS + 1;
    localparam int DIV_AMT_BITS = $clog2(DIV_AMT_MAX + 1);

    typedef logic signed [TOTAL_BITS-1:0] word_t;
    typedef logic signed [PROD_BITS-1:0]  prod_t;
    typedef logic signed [WIDE_BITS-1:0]  wide_t;
    typedef logic signed [FIELD_BITS-1:0] field_t;
    typedef logic [DIV_AMT_BITS-1:0]      div_amt_t;

    typedef enum logic [OPCODE_BITS-1:0] {
        OP_ADD     = 3'd0,
        OP_SUB     = 3'd1,
        OP_MUL     = 3'd2,
        OP_DIV     = 3'd3,
        OP_NEG     = 3'd4,
        OP_INT2FIX = 3'd5,
        OP_INTPART = 3'd6
    } op_t;

    // Comparison flags of operand a versus operand b.
    typedef struct packed {
        logic less;
        logic equal;
        logic greater;
    } flags_t;

    // Reduce a field to an operand word: sign-extend, keep the low bits.
    function automatic word_t to_operand(field_t x);
        logic signed [EXT_BITS-1:0] ext;
        ext = EXT_BITS'(x);
        return ext[TOTAL_BITS-1:0];
    endfunction

    // Clamp an intermediate to the signed operand word range.
    function automatic word_t saturate(wide_t v);
        logic all_zero;
        logic all_one;
        all_zero = ~|v[WIDE_BITS-2:TOTAL_BITS-1];
        all_one  = &v[WIDE_BITS-2:TOTAL_BITS-1];
        if (!v[WIDE_BITS-1] && !all_zero) begin
            return {1'b0, {(TOTAL_BITS-1){1'b1}}};
        end
        else if (v[WIDE_BITS-1] && !all_one) begin
            return {1'b1, {(TOTAL_BITS-1){1'b0}}};
        end
        else begin
            return v[TOTAL_BITS-1:0];
        end
    endfunction

    // Fit an operand word to the result field: sign-extend or truncate.
    function automatic field_t to_field(word_t w);
        logic signed [EXT_BITS-1:0] ext;
        ext = EXT_BITS'(w);
        return ext[FIELD_BITS-1:0];
    endfunction

endpackage

### sv/sfpa_if.sv
// ----------------------------------------------------------------------------
// Saturating fixed-point ALU channels
// Valid/ready channel interfaces for the operation items and result items.
// ----------------------------------------------------------------------------

// Operation channel: opcode and two operands.
interface sfpa_in_if;
    logic                                 valid;
    logic                                 ready;
    logic [sfpa_pkg::OPCODE_BITS-1:0]     opcode;
    logic signed [sfpa_pkg::FIELD_BITS-1:0] operand_a;
    logic signed [sfpa_pkg::FIELD_BITS-1:0] operand_b;

    modport source (output valid, output opcode, output operand_a, output operand_b,
                    input ready);
    modport sink (input valid, input opcode, input operand_a, input operand_b,
                  output ready);
endinterface

// Result channel: saturated value and comparison flags.
interface sfpa_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [sfpa_pkg::FIELD_BITS-1:0] value;
    logic                                 less;
    logic                                 equal;
    logic                                 greater;

    modport source (output valid, output value, output less, output equal,
                    output greater, input ready);
    modport sink (input valid, input value, input less, input equal, input greater,
                  output ready);
endinterface

### sv/saturating_fixed_point_alu.sv
// ----------------------------------------------------------------------------
// Saturating fixed-point ALU
// Three-stage pipelined signed fixed-point ALU with saturation and compare.
// ----------------------------------------------------------------------------
// Usage:
// Items enter on in_ch, an opcode with two signed fixed-point operands, and
// leave on out_ch as a saturated value with the signed less, equal and
// greater flags of operand a versus operand b. Both channels are valid/ready;
// an item moves at a rising edge where valid and ready are both high.
// Every item gives exactly one result item, in order.
// Each accepted item passes through the stage one, stage two and stage three
// registers before it is offered on out_ch. While out_ch does not stall,
// the pipeline takes one item per cycle.
// Stage one decodes the operands, forms the flags, the full product and the
// divide shift; stage two forms the unsaturated result; stage three
// saturates it into the output register. The one multiplier of stage one
// sets the cycle time.
// Each stage holds while the stage after it is full and stalled, so a stall
// on out_ch fills the bubbles first and then drops in_ch.ready; nothing is
// lost or repeated. Reset empties all stages; no item is offered after it.
// ----------------------------------------------------------------------------
module saturating_fixed_point_alu (
    input  logic clk,
    input  logic rst_n,
    sfpa_in_if.sink    in_ch,
    sfpa_out_if.source out_ch
);
    import sfpa_pkg::*;

    // Stage handshake: a stage takes new contents when it is empty or when
    // the stage after it takes its current contents.
    logic s1_valid_reg;
    logic s2_valid_reg;
    logic s3_valid_reg;
    logic s1_adv;
    logic s2_adv;
    logic s3_adv;

    assign s3_adv = !s3_valid_reg || out_ch.ready;
    assign s2_adv = !s2_valid_reg || s3_adv;
    assign s1_adv = !s1_valid_reg || s2_adv;
    assign in_ch.ready = s1_adv;

    // ------------------------------------------------------------------
    // Stage one: operand decode, compare, multiply, divide shift encode.
    // ------------------------------------------------------------------
    word_t    a_op;
    word_t    b_op;
    flags_t   flags_next;
    prod_t    prod_next;
    logic     div_left_next;
    div_amt_t div_amt_next;

    op_t      s1_op_reg;
    word_t    s1_a_reg;
    word_t    s1_b_reg;
    flags_t   s1_flags_reg;
    prod_t    s1_prod_reg;
    logic     s1_div_left_reg;
    div_amt_t s1_div_amt_reg;

    assign a_op = to_operand(in_ch.operand_a);
    assign b_op = to_operand(in_ch.operand_b);

    assign flags_next.less    = a_op < b_op;
    assign flags_next.equal   = a_op == b_op;
    assign flags_next.greater = a_op > b_op;

    assign prod_next = PROD_BITS'(a_op) * PROD_BITS'(b_op);

    // The divisor's top set bit, moved up one place when the bit below it is
    // also set. A zero divisor counts as position minus one. The shift is
    // that position less the fraction width: right when non-negative.
    always_comb
    begin
        logic [TOTAL_BITS:0] pat;
        int                  top;
        pat = {b_op, 1'b0};
        top = -1;
        for (int k = 0; k < TOTAL_BITS; k++)
        begin
            if (pat[k+1])
            begin
                top = pat[k] ? k + 1 : k;
            end
        end
        if (top >= FRAC_BITS)
        begin
            div_left_next = 1'b0;
            div_amt_next  = DIV_AMT_BITS'(top - FRAC_BITS);
        end
        else
        begin
            div_left_next = 1'b1;
            div_amt_next  = DIV_AMT_BITS'(FRAC_BITS - top);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= in_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && in_ch.valid)
        begin
            s1_op_reg       <= op_t'(in_ch.opcode);
            s1_a_reg        <= a_op;
            s1_b_reg        <= b_op;
            s1_flags_reg    <= flags_next;
            s1_prod_reg     <= prod_next;
            s1_div_left_reg <= div_left_next;
            s1_div_amt_reg  <= div_amt_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage two: unsaturated result per opcode.
    // ------------------------------------------------------------------
    localparam wide_t ROUND_HALF = wide_t'(1) <<< (FRAC_BITS - 1);

    wide_t  a_wide;
    wide_t  b_wide;
    wide_t  wide_next;
    wide_t  s2_wide_reg;
    flags_t s2_flags_reg;

    assign a_wide = wide_t'(s1_a_reg);
    assign b_wide = wide_t'(s1_b_reg);

    always_comb
    begin
        unique case (s1_op_reg)
            OP_ADD:     wide_next = a_wide + b_wide;
            OP_SUB:     wide_next = a_wide - b_wide;
            // Round half up: add half an LSB of the result, then shift.
            OP_MUL:     wide_next = (wide_t'(s1_prod_reg) + ROUND_HALF) >>> FRAC_BITS;
            OP_DIV:     wide_next = s1_div_left_reg ? (a_wide <<< s1_div_amt_reg) :
                                                      (a_wide >>> s1_div_amt_reg);
            OP_NEG:     wide_next = -a_wide;
            OP_INT2FIX: wide_next = a_wide <<< FRAC_BITS;
            OP_INTPART: wide_next = a_wide >>> FRAC_BITS;
            default:    wide_next = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s2_adv)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_adv && s1_valid_reg)
        begin
            s2_wide_reg  <= wide_next;
            s2_flags_reg <= s1_flags_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage three: saturation into the output register.
    // ------------------------------------------------------------------
    field_t value_next;
    field_t s3_value_reg;
    flags_t s3_flags_reg;

    assign value_next = to_field(saturate(s2_wide_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else if (s3_adv)
        begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_adv && s2_valid_reg)
        begin
            s3_value_reg <= value_next;
            s3_flags_reg <= s2_flags_reg;
        end
    end

    assign out_ch.valid   = s3_valid_reg;
    assign out_ch.value   = s3_value_reg;
    assign out_ch.less    = s3_flags_reg.less;
    assign out_ch.equal   = s3_flags_reg.equal;
    assign out_ch.greater = s3_flags_reg.greater;

`ifndef SYNTHESIS
    // Exactly one comparison flag is set on every offered result.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> $onehot({out_ch.less, out_ch.equal, out_ch.greater}))
        else $error("comparison flags not one-hot");

    // An accepted item occupies stage one at the next edge.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready) |=> s1_valid_reg)
        else $error("accepted item lost at stage one");

    // A full stage one that cannot advance keeps its product and flags.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s2_adv) |=> (s1_valid_reg && $stable(s1_prod_reg)
                                       && $stable(s1_flags_reg)))
        else $error("stalled stage one changed");

    // A full stage two that cannot advance keeps its intermediate.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && !s3_adv) |=> (s2_valid_reg && $stable(s2_wide_reg)))
        else $error("stalled stage two changed");
`endif

endmodule
